// ===== rtl/core/ldw_pkg.sv =====
`timescale 1ns / 1ps

package ldw_pkg;

	localparam int TICKS_PER_US     = 10;
	localparam int US_PER_MS        = 1000;
	localparam int TIMEOUT_RESET_MS = 1000;

	localparam int TIME_W    = 64;
	localparam int FEED_W    = 32;
	localparam int MS_W      = 16;
	localparam int US_W      = 26;
	localparam int MODE_W    = 2;

	localparam int CHUNK_W    = 16;
	localparam int NUM_CHUNKS = TIME_W / CHUNK_W;
	localparam int REM_W      = 4;
	localparam int DIG_W      = REM_W + CHUNK_W;
	localparam int DIV_SHIFT  = DIG_W + REM_W;
	localparam int RECIP_W    = DIV_SHIFT - REM_W + 1;
	localparam int PROD_W     = DIG_W + RECIP_W;

	localparam logic [RECIP_W-1:0] DIV_RECIP =
		RECIP_W'(((2 ** DIV_SHIFT) + TICKS_PER_US - 1) / TICKS_PER_US);
	localparam logic [US_W-1:0] TIMEOUT_RESET_US = US_W'(TIMEOUT_RESET_MS * US_PER_MS);
	localparam logic [US_W-1:0] US_PER_MS_C      = US_W'(US_PER_MS);

	typedef enum logic [MODE_W-1:0] {
		MODE_QUERY = 2'd0,
		MODE_START = 2'd1,
		MODE_FEED  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [TIME_W-1:0] now_us;
	} ldw_item_t;

	typedef struct packed {
		logic [CHUNK_W-1:0] q;
		logic [REM_W-1:0]   r;
	} div_step_t;

	function automatic div_step_t div10_digit(input logic [REM_W-1:0] r_in,
		input logic [CHUNK_W-1:0] chunk);
		logic [DIG_W-1:0]  v;
		logic [PROD_W-1:0] prod;
		logic [DIG_W-1:0]  qx10;
		div_step_t         res;
		v        = {r_in, chunk};
		prod     = PROD_W'(v) * PROD_W'(DIV_RECIP);
		res.q    = prod[DIV_SHIFT +: CHUNK_W];
		qx10     = (DIG_W'(res.q) << 3) + (DIG_W'(res.q) << 1);
		res.r    = REM_W'(v - qx10);
		return res;
	endfunction

endpackage

// ===== rtl/core/ldw_if.sv =====
`timescale 1ns / 1ps

interface ldw_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [ldw_pkg::MODE_W-1:0]        mode;
	logic [ldw_pkg::TIME_W-1:0]        mtime_ticks;

	modport source (output valid, output mode, output mtime_ticks, input ready);
	modport sink   (input valid, input mode, input mtime_ticks, output ready);
endinterface

interface ldw_status_if;
	logic                              valid;
	logic                              ready;
	logic                              expired;
	logic                              running;
	logic [ldw_pkg::FEED_W-1:0]        feed_count;

	modport source (output valid, output expired, output running, output feed_count,
		input ready);
	modport sink   (input valid, input expired, input running, input feed_count,
		output ready);
endinterface

// ===== rtl/core/ldw_div10.sv =====
`timescale 1ns / 1ps

module ldw_div10 (
	input  logic                clk,
	input  logic                arst_n,
	ldw_cmd_if.sink             cmd,
	output logic                item_valid,
	input  logic                item_ready,
	output ldw_pkg::ldw_item_t  item
);

	localparam int NS = ldw_pkg::NUM_CHUNKS + 1;

	logic [NS-1:0]                      vld_s;
	logic [ldw_pkg::MODE_W-1:0]         mode_s [NS];
	logic [ldw_pkg::TIME_W-1:0]         work_s [NS];
	logic [ldw_pkg::REM_W-1:0]          rem_s  [NS];

	logic [NS:0]                        adv;
	ldw_pkg::div_step_t                 step   [1:NS-1];
	logic [ldw_pkg::TIME_W-1:0]         work_n [1:NS-1];

	always_comb begin
		adv[NS] = item_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	// one decimal long-division step per stage, most significant chunk first
	always_comb begin
		for (int k = 1; k < NS; k++) begin
			step[k]   = ldw_pkg::div10_digit(rem_s[k-1],
				work_s[k-1][ldw_pkg::CHUNK_W*(NS-1-k) +: ldw_pkg::CHUNK_W]);
			work_n[k] = work_s[k-1];
			work_n[k][ldw_pkg::CHUNK_W*(NS-1-k) +: ldw_pkg::CHUNK_W] = step[k].q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= cmd.valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0] && cmd.valid) begin
			mode_s[0] <= cmd.mode;
			work_s[0] <= cmd.mtime_ticks;
			rem_s[0]  <= '0;
		end
		for (int k = 1; k < NS; k++) begin
			if (adv[k] && vld_s[k-1]) begin
				mode_s[k] <= mode_s[k-1];
				work_s[k] <= work_n[k];
				rem_s[k]  <= step[k].r;
			end
		end
	end

	assign cmd.ready   = adv[0];
	assign item_valid  = vld_s[NS-1];
	assign item.mode   = mode_s[NS-1];
	assign item.now_us = work_s[NS-1];

endmodule

// ===== rtl/core/ldw_core.sv =====
`timescale 1ns / 1ps

module ldw_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ldw_pkg::MS_W-1:0]    cfg_wdata,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  ldw_pkg::ldw_item_t          item,
	ldw_status_if.source                status
);

	logic [ldw_pkg::US_W-1:0]    tout_us_q;
	logic [ldw_pkg::US_W-1:0]    lat_us_q;
	logic                        run_q;
	logic                        exp_q;
	logic [ldw_pkg::FEED_W-1:0]  feeds_q;
	logic [ldw_pkg::TIME_W-1:0]  dl_q;

	logic                        out_vld_q;
	logic                        out_exp_q;
	logic                        out_run_q;
	logic [ldw_pkg::FEED_W-1:0]  out_feeds_q;

	logic                        fire;
	logic [ldw_pkg::US_W-1:0]    lat_n;
	logic                        run_n;
	logic                        exp_n;
	logic [ldw_pkg::FEED_W-1:0]  feeds_n;
	logic [ldw_pkg::TIME_W-1:0]  dl_n;
	logic [ldw_pkg::TIME_W-1:0]  dl_start;
	logic [ldw_pkg::TIME_W-1:0]  dl_feed;
	logic [ldw_pkg::TIME_W-1:0]  diff;

	assign item_ready = !out_vld_q || status.ready;
	assign fire       = item_valid && item_ready;

	assign dl_start = item.now_us + ldw_pkg::TIME_W'(tout_us_q);
	assign dl_feed  = item.now_us + ldw_pkg::TIME_W'(lat_us_q);
	assign diff     = item.now_us - dl_q;

	always_comb begin
		lat_n   = lat_us_q;
		run_n   = run_q;
		exp_n   = exp_q;
		feeds_n = feeds_q;
		dl_n    = dl_q;
		case (item.mode)
			ldw_pkg::MODE_START: begin
				run_n   = 1'b1;
				exp_n   = 1'b0;
				feeds_n = '0;
				lat_n   = tout_us_q;
				dl_n    = dl_start;
			end
			ldw_pkg::MODE_FEED: begin
				if (run_q && !exp_q) begin
					feeds_n = feeds_q + ldw_pkg::FEED_W'(1);
					dl_n    = dl_feed;
				end
			end
			ldw_pkg::MODE_QUERY: begin
				// deadline reached when the wrapped difference is in the lower half
				if (run_q && !diff[ldw_pkg::TIME_W-1]) begin
					exp_n = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tout_us_q <= ldw_pkg::TIMEOUT_RESET_US;
		end else if (cfg_we) begin
			tout_us_q <= ldw_pkg::US_W'(cfg_wdata) * ldw_pkg::US_PER_MS_C;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_us_q  <= '0;
			run_q     <= 1'b0;
			exp_q     <= 1'b0;
			feeds_q   <= '0;
			dl_q      <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (fire) begin
				lat_us_q <= lat_n;
				run_q    <= run_n;
				exp_q    <= exp_n;
				feeds_q  <= feeds_n;
				dl_q     <= dl_n;
			end
			if (item_ready) begin
				out_vld_q <= item_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_exp_q   <= run_n && exp_n;
			out_run_q   <= run_n;
			out_feeds_q <= feeds_n;
		end
	end

	assign status.valid      = out_vld_q;
	assign status.expired    = out_exp_q;
	assign status.running    = out_run_q;
	assign status.feed_count = out_feeds_q;

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.mode == ldw_pkg::MODE_START
		|=> out_vld_q && out_run_q && !out_exp_q && out_feeds_q == '0)
		else $error("start did not clear status");

	a_latch_holds: assert property (@(posedge clk) disable iff (!arst_n)
		exp_q && !(fire && item.mode == ldw_pkg::MODE_START) |=> exp_q)
		else $error("expiry latch dropped without start");

	a_run_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |=> run_q)
		else $error("running flag fell");

	a_feeds_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(feeds_q) && $stable(dl_q))
		else $error("state moved without a word");

endmodule

// ===== rtl/core/latched_deadline_watchdog.sv =====
`timescale 1ns / 1ps

// channel   dir   handshake            payload
// cmd       in    valid / ready        mode[1:0], mtime_ticks[63:0]
// status    out   valid / ready        expired, running, feed_count[31:0]
// cfg       in    cfg_we (no ready)    cfg_wdata[15:0] = watchdog period in ms
//
// One word accepted per cycle while the status channel does not stall; each status word passes through
// the input register, four 16-bit divide-by-ten stages and the status register.
// arst_n clears the valid bits and the core's flags and counters; the period resets to 1000 ms.
// A stalled status word holds; cmd.ready drops only once every stage is full.

module latched_deadline_watchdog (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ldw_pkg::MS_W-1:0]    cfg_wdata,
	ldw_cmd_if.sink                     cmd,
	ldw_status_if.source                status
);

	logic                item_valid;
	logic                item_ready;
	ldw_pkg::ldw_item_t  item;

	ldw_div10 u_div10 (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	ldw_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.status     (status)
	);

endmodule
